// ----- rtl/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and field widths of the byte ring buffer.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int OP_W    = 3;
    localparam int FIELD_W = 13;
    localparam int DATA_W  = 64;
    localparam int NB_W    = 4;
    localparam int LANES   = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ    = 3'd0,
        OP_DEQ    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_ADV_RD = 3'd3,
        OP_ADV_WR = 3'd4,
        OP_STATUS = 3'd5
    } t_op;

endpackage

// ----- rtl/byte_ring_fifo_multibyte_unit.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_multibyte_unit
// Byte ring buffer over one synchronous byte memory: enqueue, dequeue, peek,
// pointer advance and status, each answered with one or more result beats.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              fields
//  request   in         start && !busy         i_op, i_count, i_payload
//  result    out        o_valid, one cycle     o_ok .. o_write_index
//
//  enqueue of n bytes: one memory write per byte, then one result
//  dequeue / peek of n bytes: one byte read per cycle, beats of 8, the last may be shorter
//  advance: one compare-subtract per cycle over the modulo reduction
//  status, rejected and zero-byte requests: result in the cycle after accept
//  reset clears both pointers; memory content is undefined until written
//  the receiver cannot stall: each result shows for one cycle only
module byte_ring_fifo_multibyte_unit #(
    parameter int DEPTH    = 8192,
    parameter int MAX_READ = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [brf_pkg::OP_W-1:0]    i_op,
    input  logic [brf_pkg::FIELD_W-1:0] i_count,
    input  logic [brf_pkg::DATA_W-1:0]  i_payload,
    output logic                        o_valid,
    output logic                        o_ok,
    output logic [brf_pkg::DATA_W-1:0]  o_read_bytes,
    output logic [brf_pkg::NB_W-1:0]    o_beat_bytes,
    output logic                        o_last_beat,
    output logic [brf_pkg::FIELD_W-1:0] o_used_count,
    output logic [brf_pkg::FIELD_W-1:0] o_free_count,
    output logic [brf_pkg::FIELD_W-1:0] o_read_run,
    output logic [brf_pkg::FIELD_W-1:0] o_write_run,
    output logic [brf_pkg::FIELD_W-1:0] o_read_index,
    output logic [brf_pkg::FIELD_W-1:0] o_write_index
);
    import brf_pkg::*;

    localparam int PW  = $clog2(DEPTH);
    localparam int CW  = PW + 1;
    localparam int XW  = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int RW  = $clog2(MAX_READ + 1);
    localparam int VW  = $clog2(DEPTH + 8192);
    localparam int NS  = $clog2(8192 / DEPTH + 2);
    localparam int SHW = $clog2(NS + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(DEPTH - 1);

    typedef enum logic [2:0] {S_IDLE, S_WRITE, S_READ, S_MOD, S_RESP} t_state;

    function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // state and output registers
    t_state              r_state, n_state;
    logic [PW-1:0]       r_rp, n_rp, r_wp, n_wp, r_pos, n_pos;
    logic [3:0]          r_left, n_left;
    logic [DATA_W-1:0]   r_pay, n_pay, r_beat, n_beat;
    logic [RW-1:0]       r_cnt, n_cnt, r_iss, n_iss, r_got, n_got;
    logic [2:0]          r_lane, n_lane;
    logic                r_rvld, n_rvld;
    logic [VW-1:0]       r_v, n_v;
    logic [SHW-1:0]      r_sh, n_sh;
    logic                r_adv_wr, n_adv_wr;
    logic                r_valid, n_valid, r_ok, n_ok, r_last, n_last;
    logic [DATA_W-1:0]   r_data, n_data;
    logic [NB_W-1:0]     r_nb, n_nb;
    logic [FIELD_W-1:0]  r_used, r_free, r_rrun, r_wrun, r_ri, r_wi;

    // memory ports
    logic [7:0]          mem [DEPTH];
    logic                mem_we;
    logic [PW-1:0]       mem_waddr, mem_raddr;
    logic [7:0]          mem_wdata, mem_rdata;

    // status from current pointers
    logic [CW-1:0] used, freeb, rrun_raw, wrun_raw, rrun, wrun;
    logic [PW-1:0] ri, wi;
    always_comb begin
        used     = (r_wp >= r_rp) ? CW'(r_wp) - CW'(r_rp) : CW'(r_wp) + DEPTH_C - CW'(r_rp);
        freeb    = LAST_C - used;
        ri       = wrap_next(r_rp);
        wi       = wrap_next(r_wp);
        rrun_raw = DEPTH_C - CW'(ri);
        wrun_raw = DEPTH_C - CW'(wi);
        rrun     = (used < rrun_raw) ? used : rrun_raw;
        wrun     = (freeb < wrun_raw) ? freeb : wrun_raw;
    end

    // request decode
    logic [XW-1:0]   cnt_x, used_x, free_x;
    logic            enq_fail, rd_fail;
    logic [XW:0]     deq_sum;
    logic [VW:0]     sub_val;
    logic [DATA_W-1:0] merged;
    logic            beat_end, got_last;
    always_comb begin
        cnt_x    = XW'(i_count);
        used_x   = XW'(used);
        free_x   = XW'(freeb);
        enq_fail = (i_count > FIELD_W'(LANES)) || (freeb == '0) || (free_x < cnt_x);
        rd_fail  = (i_count > FIELD_W'(MAX_READ)) || (used == '0) || (used_x < cnt_x);
        deq_sum  = (XW + 1)'(r_rp) + (XW + 1)'(i_count);
        sub_val  = (VW + 1)'(DEPTH) << r_sh;
        merged   = r_beat | (DATA_W'(mem_rdata) << {r_lane, 3'b000});
        got_last = ((r_got + 1'b1) == r_cnt);
        beat_end = (r_lane == 3'd7) || got_last;
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_rp = r_rp; n_wp = r_wp; n_pos = r_pos;
        n_left = r_left; n_pay = r_pay; n_beat = r_beat; n_cnt = r_cnt;
        n_iss = r_iss; n_got = r_got; n_lane = r_lane; n_rvld = 1'b0;
        n_v = r_v; n_sh = r_sh; n_adv_wr = r_adv_wr;
        n_valid = 1'b0; n_ok = r_ok; n_last = r_last; n_data = r_data; n_nb = r_nb;
        mem_we = 1'b0; mem_waddr = wrap_next(r_wp); mem_wdata = r_pay[7:0];
        mem_raddr = wrap_next(r_pos);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    // single result unless changed below
                    n_valid = 1'b1; n_ok = 1'b0; n_data = '0; n_nb = '0; n_last = 1'b1;
                    priority case (i_op)
                        OP_ENQ: begin
                            if (!enq_fail) begin
                                if (i_count == '0) begin
                                    n_ok = 1'b1;
                                end else begin
                                    n_valid = 1'b0;
                                    n_left  = i_count[3:0];
                                    n_pay   = i_payload;
                                    n_state = S_WRITE;
                                end
                            end
                        end
                        OP_DEQ, OP_PEEK: begin
                            if (!rd_fail) begin
                                if (i_count == '0) begin
                                    n_ok = 1'b1;
                                end else begin
                                    n_valid = 1'b0;
                                    n_pos   = r_rp;
                                    n_cnt   = RW'(i_count);
                                    n_iss   = '0;
                                    n_got   = '0;
                                    n_lane  = '0;
                                    n_beat  = '0;
                                    n_state = S_READ;
                                    if (i_op == OP_DEQ) begin
                                        n_rp = (deq_sum >= (XW + 1)'(DEPTH)) ?
                                               PW'(deq_sum - (XW + 1)'(DEPTH)) : PW'(deq_sum);
                                    end
                                end
                            end
                        end
                        OP_ADV_RD, OP_ADV_WR: begin
                            n_valid  = 1'b0;
                            n_adv_wr = (i_op == OP_ADV_WR);
                            n_v      = VW'((i_op == OP_ADV_WR) ? r_wp : r_rp) + VW'(i_count);
                            n_sh     = SHW'(NS - 1);
                            n_state  = S_MOD;
                        end
                        OP_STATUS: n_ok = 1'b1;
                        default:   n_ok = 1'b0;
                    endcase
                end
            end
            S_WRITE: begin
                // one byte per cycle at the slot after the write pointer
                mem_we = 1'b1;
                n_wp   = wrap_next(r_wp);
                n_pay  = r_pay >> 8;
                n_left = r_left - 1'b1;
                if (r_left == 4'd1) n_state = S_RESP;
            end
            S_READ: begin
                // issue one address a cycle, gather returning bytes into lanes
                if (r_iss != r_cnt) begin
                    n_pos  = wrap_next(r_pos);
                    n_iss  = r_iss + 1'b1;
                    n_rvld = 1'b1;
                end
                if (r_rvld) begin
                    n_got  = r_got + 1'b1;
                    n_lane = r_lane + 1'b1;
                    n_beat = merged;
                    if (beat_end) begin
                        n_valid = 1'b1; n_ok = 1'b1; n_data = merged;
                        n_nb    = NB_W'(r_lane) + 1'b1;
                        n_last  = got_last;
                        n_lane  = '0;
                        n_beat  = '0;
                        if (got_last) n_state = S_IDLE;
                    end
                end
            end
            S_MOD: begin
                // restoring reduction of pointer plus amount modulo depth
                if ({1'b0, r_v} >= sub_val) n_v = VW'({1'b0, r_v} - sub_val);
                n_sh = r_sh - 1'b1;
                if (r_sh == '0) begin
                    n_state = S_RESP;
                    if ({1'b0, r_v} >= sub_val) begin
                        if (r_adv_wr) n_wp = PW'({1'b0, r_v} - sub_val);
                        else          n_rp = PW'({1'b0, r_v} - sub_val);
                    end else begin
                        if (r_adv_wr) n_wp = PW'(r_v);
                        else          n_rp = PW'(r_v);
                    end
                end
            end
            S_RESP: begin
                n_valid = 1'b1; n_ok = 1'b1; n_data = '0; n_nb = '0; n_last = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_rvld  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_rvld  <= n_rvld;
            r_valid <= n_valid;
        end
        r_pos <= n_pos; r_left <= n_left; r_pay <= n_pay; r_beat <= n_beat;
        r_cnt <= n_cnt; r_iss <= n_iss; r_got <= n_got; r_lane <= n_lane;
        r_v <= n_v; r_sh <= n_sh; r_adv_wr <= n_adv_wr;
        r_ok <= n_ok; r_last <= n_last; r_data <= n_data; r_nb <= n_nb;
        // pointers are final whenever a result is captured
        if (n_valid) begin
            r_used <= FIELD_W'(used);
            r_free <= FIELD_W'(freeb);
            r_rrun <= FIELD_W'(rrun);
            r_wrun <= FIELD_W'(wrun);
            r_ri   <= FIELD_W'(ri);
            r_wi   <= FIELD_W'(wi);
        end
    end

    // byte memory; the read port reads every cycle, but its data is used only in S_READ, which never writes
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        mem_rdata <= mem[mem_raddr];
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_ok          = r_ok;
    assign o_read_bytes  = r_data;
    assign o_beat_bytes  = r_nb;
    assign o_last_beat   = r_last;
    assign o_used_count  = r_used;
    assign o_free_count  = r_free;
    assign o_read_run    = r_rrun;
    assign o_write_run   = r_wrun;
    assign o_read_index  = r_ri;
    assign o_write_index = r_wi;

`ifndef SYNTH
    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_last_beat && (o_beat_bytes == '0))
        else $error("rejected request gave a data beat");
    a_full_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_beat |-> (o_beat_bytes == NB_W'(LANES)))
        else $error("short beat before the last one");
    a_counts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (FIELD_W'(o_used_count + o_free_count) == FIELD_W'(DEPTH - 1)))
        else $error("used and free counts disagree with depth");
    a_accept_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted request neither answered nor in progress");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte ring buffer: a scoreboard predicts every
// result beat of each accepted request and checks the result port against it.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import brf_pkg::*;

    localparam int DEPTH    = 8192;
    localparam int MAX_READ = 64;

    typedef struct {
        bit               ok;
        bit [DATA_W-1:0]  data;
        bit [NB_W-1:0]    nb;
        bit               last;
        bit [FIELD_W-1:0] used;
        bit [FIELD_W-1:0] free;
        bit [FIELD_W-1:0] rrun;
        bit [FIELD_W-1:0] wrun;
        bit [FIELD_W-1:0] ridx;
        bit [FIELD_W-1:0] widx;
    } t_beat;

    // ring model plus the queue of beats still due from the block
    class ring_scoreboard;
        bit [7:0]    mem [DEPTH];
        bit          filled [DEPTH];
        int unsigned rd_ptr;
        int unsigned wr_ptr;
        t_beat       due_beats[$];
        int          errors;

        function new();
            rd_ptr = 0;
            wr_ptr = 0;
            errors = 0;
        endfunction

        function int unsigned used_now();
            return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
        endfunction

        function int unsigned step(int unsigned p);
            return (p + 1 >= DEPTH) ? 0 : p + 1;
        endfunction

        // a read that would succeed must only touch bytes written before
        function bit read_is_safe(int unsigned cnt);
            int unsigned p;
            int unsigned u;
            u = used_now();
            if (cnt > MAX_READ || u == 0 || u < cnt || cnt == 0) return 1;
            p = rd_ptr;
            for (int unsigned i = 0; i < cnt; i++) begin
                p = step(p);
                if (!filled[p]) return 0;
            end
            return 1;
        endfunction

        function void push_beat(bit ok, bit [DATA_W-1:0] data, int unsigned nb, bit last);
            t_beat b;
            int unsigned u, f, ri, wi, rr, wrn;
            u   = used_now();
            f   = DEPTH - 1 - u;
            ri  = step(rd_ptr);
            wi  = step(wr_ptr);
            rr  = DEPTH - ri;
            wrn = DEPTH - wi;
            if (u < rr) rr = u;
            if (f < wrn) wrn = f;
            b.ok = ok; b.data = data; b.nb = nb[NB_W-1:0]; b.last = last;
            b.used = u[FIELD_W-1:0]; b.free = f[FIELD_W-1:0];
            b.rrun = rr[FIELD_W-1:0]; b.wrun = wrn[FIELD_W-1:0];
            b.ridx = ri[FIELD_W-1:0]; b.widx = wi[FIELD_W-1:0];
            due_beats.push_back(b);
        endfunction

        // predict all beats caused by one accepted request
        function void note_request(bit [OP_W-1:0] op, bit [FIELD_W-1:0] count,
                                   bit [DATA_W-1:0] payload);
            int unsigned cnt, u, f, pos, done, nb;
            bit [DATA_W-1:0] data;
            cnt = 32'(count);
            u   = used_now();
            f   = DEPTH - 1 - u;
            case (op)
                OP_ENQ: begin
                    if (cnt > 8 || f == 0 || f < cnt) begin
                        push_beat(0, '0, 0, 1);
                    end else begin
                        for (int unsigned i = 0; i < cnt; i++) begin
                            wr_ptr = step(wr_ptr);
                            mem[wr_ptr]    = payload[8*i +: 8];
                            filled[wr_ptr] = 1;
                        end
                        push_beat(1, '0, 0, 1);
                    end
                end
                OP_DEQ, OP_PEEK: begin
                    if (cnt > MAX_READ || u == 0 || u < cnt) begin
                        push_beat(0, '0, 0, 1);
                    end else if (cnt == 0) begin
                        push_beat(1, '0, 0, 1);
                    end else begin
                        pos = rd_ptr;
                        if (op == OP_DEQ) rd_ptr = (rd_ptr + cnt) % DEPTH;
                        done = 0;
                        while (done < cnt) begin
                            data = '0;
                            nb = (cnt - done > 8) ? 8 : cnt - done;
                            for (int unsigned j = 0; j < nb; j++) begin
                                pos = step(pos);
                                data[8*j +: 8] = mem[pos];
                            end
                            done += nb;
                            push_beat(1, data, nb, done >= cnt);
                        end
                    end
                end
                OP_ADV_RD: begin
                    rd_ptr = (rd_ptr + cnt) % DEPTH;
                    push_beat(1, '0, 0, 1);
                end
                OP_ADV_WR: begin
                    wr_ptr = (wr_ptr + cnt) % DEPTH;
                    push_beat(1, '0, 0, 1);
                end
                OP_STATUS: push_beat(1, '0, 0, 1);
                default:   push_beat(0, '0, 0, 1);
            endcase
        endfunction

        function void cmp(string name, bit [DATA_W-1:0] exp_v, bit [DATA_W-1:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name,
                         exp_v, act_v);
            end
        endfunction

        function void check_result(t_beat act);
            t_beat e;
            if (due_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: expected none, actual %p",
                         $realtime, act);
                return;
            end
            e = due_beats.pop_front();
            cmp("ok",          e.ok,   act.ok);
            cmp("read_bytes",  e.data, act.data);
            cmp("beat_bytes",  e.nb,   act.nb);
            cmp("last_beat",   e.last, act.last);
            cmp("used_count",  e.used, act.used);
            cmp("free_count",  e.free, act.free);
            cmp("read_run",    e.rrun, act.rrun);
            cmp("write_run",   e.wrun, act.wrun);
            cmp("read_index",  e.ridx, act.ridx);
            cmp("write_index", e.widx, act.widx);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [OP_W-1:0]      i_op;
    logic [FIELD_W-1:0]   i_count;
    logic [DATA_W-1:0]    i_payload;
    logic                 o_valid;
    logic                 o_ok;
    logic [DATA_W-1:0]    o_read_bytes;
    logic [NB_W-1:0]      o_beat_bytes;
    logic                 o_last_beat;
    logic [FIELD_W-1:0]   o_used_count;
    logic [FIELD_W-1:0]   o_free_count;
    logic [FIELD_W-1:0]   o_read_run;
    logic [FIELD_W-1:0]   o_write_run;
    logic [FIELD_W-1:0]   o_read_index;
    logic [FIELD_W-1:0]   o_write_index;

    ring_scoreboard sb = new();
    int             idle_pct;

    byte_ring_fifo_multibyte_unit #(.DEPTH(DEPTH), .MAX_READ(MAX_READ)) dut (.*);

    // clock
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        t_beat act;
        if (i_rst_n && o_valid) begin
            act.ok = o_ok; act.data = o_read_bytes; act.nb = o_beat_bytes;
            act.last = o_last_beat; act.used = o_used_count; act.free = o_free_count;
            act.rrun = o_read_run; act.wrun = o_write_run;
            act.ridx = o_read_index; act.widx = o_write_index;
            sb.check_result(act);
        end
    end

    // drive one request, with a random idle gap first, until accepted
    task automatic send_request(bit [OP_W-1:0] op, bit [FIELD_W-1:0] count,
                                bit [DATA_W-1:0] payload);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 0;
        end
        // never hand the block a read of bytes that were never stored
        if ((op == OP_DEQ || op == OP_PEEK) && !sb.read_is_safe(32'(count))) op = OP_ADV_RD;
        @(negedge i_clk);
        start     <= 1;
        i_op      <= op;
        i_count   <= count;
        i_payload <= payload;
        do @(posedge i_clk); while (busy);
        sb.note_request(op, count, payload);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 0;
        while (sb.due_beats.size() != 0) @(posedge i_clk);
    endtask

    function automatic bit [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one random request, mostly enqueue/dequeue traffic of legal sizes
    task automatic random_request();
        int sel;
        bit [FIELD_W-1:0] cnt;
        bit [OP_W-1:0]    op;
        sel = $urandom_range(99);
        if (sel < 45) begin
            op  = OP_ENQ;
            cnt = ($urandom_range(9) == 0) ? FIELD_W'($urandom)
                                           : FIELD_W'($urandom_range(0, 8));
        end else if (sel < 80) begin
            op  = (sel < 65) ? OP_DEQ : OP_PEEK;
            cnt = ($urandom_range(9) == 0) ? FIELD_W'($urandom)
                                           : FIELD_W'($urandom_range(0, MAX_READ));
        end else if (sel < 88) begin
            op  = ($urandom_range(1)) ? OP_ADV_RD : OP_ADV_WR;
            case ($urandom_range(2))
                0: cnt = FIELD_W'($urandom_range(0, 16));
                1: cnt = FIELD_W'(DEPTH - $urandom_range(1, 16));
                default: cnt = FIELD_W'($urandom);
            endcase
        end else if (sel < 92) begin
            // re-empty the ring so the next traffic starts clean
            op  = OP_ADV_RD;
            cnt = FIELD_W'(sb.used_now());
        end else if (sel < 96) begin
            op  = OP_STATUS;
            cnt = FIELD_W'($urandom);
        end else begin
            op  = OP_W'($urandom_range(6, 7));
            cnt = FIELD_W'($urandom);
        end
        send_request(op, cnt, rand64());
    endtask

    initial begin
        int phase_pct [3] = '{0, 67, 20};
        int limit;
        start     = 0;
        i_op      = OP_STATUS;
        i_count   = '0;
        i_payload = '0;
        i_rst_n   = 0;
        idle_pct  = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: empty, beats, oversize, unknown ops, wrap, full, short room
        send_request(OP_STATUS, '0, '0);
        send_request(OP_ENQ, 0, rand64());
        send_request(OP_DEQ, 1, '0);
        send_request(OP_PEEK, 0, '0);
        send_request(OP_ENQ, 8, '1);
        send_request(OP_ENQ, 3, 64'hDEAD_BEEF_CAFE_1234);
        send_request(OP_PEEK, 11, '0);
        send_request(OP_DEQ, 64, '0);
        send_request(OP_DEQ, 11, '0);
        send_request(OP_ENQ, 9, rand64());
        send_request(OP_DEQ, 65, '0);
        send_request(3'd6, '1, '1);
        send_request(3'd7, '0, '0);
        send_request(OP_ADV_WR, 8185, '0);
        send_request(OP_ADV_RD, 8185, '0);
        repeat (8) send_request(OP_ENQ, 8, rand64());
        send_request(OP_PEEK, FIELD_W'(MAX_READ), '0);
        send_request(OP_DEQ, FIELD_W'(MAX_READ), '0);
        send_request(OP_ADV_WR, FIELD_W'(DEPTH - 1), '0);
        send_request(OP_ENQ, 1, rand64());
        send_request(OP_ENQ, 0, rand64());
        send_request(OP_ADV_RD, '1, '0);
        send_request(OP_ADV_WR, FIELD_W'(DEPTH - 6), '0);
        send_request(OP_ENQ, 8, rand64());
        send_request(OP_ADV_RD, FIELD_W'(sb.used_now()), '0);
        drain();

        // random phases at different sender idle rates
        foreach (phase_pct[p]) begin
            idle_pct = phase_pct[p];
            repeat (96) random_request();
            // hold off until the block has answered everything
            drain();
        end

        limit = 0;
        while (sb.due_beats.size() != 0 && limit < 10000) begin
            @(posedge i_clk);
            limit++;
        end
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_beats.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
